### rtl/core/selective_repeat_receive_window_assert.svh
// Assertion macros for the selective-repeat receive window.
// Included by the top level; define NO_ASSERTIONS to leave them out.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRW_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRW_ASSERT(label, clk, rst_n, prop, msg)
`define SRW_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/core/srw_pkg.sv
// Shared types and constants for the selective-repeat receive window.
// No dependencies.
package srw_pkg;
  localparam int WindowDef = 16;
  localparam int SegBytesDef = 1000;
  localparam int PosW = 16;
  localparam int OffW = 25;
  localparam int LenW = 10;
  localparam int TimeW = 32;
  localparam int TotW = 25;
  localparam int RenW = 16;
  localparam int CfgDataW = 25;

  localparam logic [1:0] ModeStart = 2'd0;
  localparam logic [1:0] ModeTick = 2'd1;
  localparam logic [1:0] ModeArrival = 2'd2;
  localparam logic KindRequest = 1'b0;
  localparam logic KindDeliver = 1'b1;
  localparam logic CfgTotal = 1'b0;
  localparam logic CfgRenewal = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [30:0] arrival_offset;
    logic [15:0] arrival_length;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic [15:0] segment_index;
    logic [24:0] byte_offset;
    logic [9:0] byte_length;
    logic last;
  } out_item_t;

  // Control handed from the sequencer to every cell in a cycle.
  typedef struct packed {
    logic rotate;
    logic req_head;
    logic clr_head;
    logic set_ld;
  } cell_ctl_t;
endpackage

### rtl/core/srw_cell.sv
// One window slot: loaded and requested flags and last request time.
// Depends on srw_pkg. Cells form a ring that rotates by one on a slide.
module srw_cell (
  input  logic clk,
  input  logic rst_n,
  input  srw_pkg::cell_ctl_t ctl,
  input  logic is_head,
  input  logic sel_ld,
  input  logic [srw_pkg::TimeW-1:0] now,
  input  logic prev_ld,
  input  logic prev_rq,
  input  logic [srw_pkg::TimeW-1:0] prev_tm,
  output logic ld,
  output logic rq,
  output logic [srw_pkg::TimeW-1:0] tm
);
  import srw_pkg::*;
  logic ld_r, ld_nxt, rq_r, rq_nxt;
  logic [TimeW-1:0] tm_r, tm_nxt;

  always_comb begin
    ld_nxt = ld_r;
    rq_nxt = rq_r;
    tm_nxt = tm_r;
    if (ctl.rotate) begin
      ld_nxt = prev_ld;
      rq_nxt = prev_rq;
      tm_nxt = prev_tm;
    end else if (ctl.req_head && is_head) begin
      rq_nxt = 1'b1;
      tm_nxt = now;
    end else if (ctl.clr_head && is_head) begin
      ld_nxt = 1'b0;
      rq_nxt = 1'b0;
    end else if (ctl.set_ld && sel_ld) begin
      ld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r <= 1'b0;
      rq_r <= 1'b0;
    end else begin
      ld_r <= ld_nxt;
      rq_r <= rq_nxt;
    end
    tm_r <= tm_nxt;
  end

  assign ld = ld_r;
  assign rq = rq_r;
  assign tm = tm_r;
endmodule

### rtl/core/selective_repeat_receive_window.sv
// Channel  | Ports                        | Transfer
// input    | start, busy, in_item         | start high while busy low
// result   | out_valid, out_item          | one cycle per strobe, no stall
// config   | cfg_we, cfg_index, cfg_data  | any edge with cfg_we high
// Cells form a ring; cell 0 holds the slot of the window base and a slide rotates the ring.
// Start and tick walk the WINDOW positions of the ring, one result at most per cycle, and
// then pass through a closing state. An arrival is checked in two states, each released
// segment takes a release state and a slide state, and a closing state ends a release. The
// final result leaves through the holding register, and busy stays high until it has gone.
// Reset is synchronous and needs no clearing pass; results cannot be held off.
// Depends on srw_pkg, srw_cell and the assertion header.
`include "selective_repeat_receive_window_assert.svh"
module selective_repeat_receive_window #(
  parameter int WINDOW = srw_pkg::WindowDef,
  parameter int SEGMENT_BYTES = srw_pkg::SegBytesDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  srw_pkg::in_item_t in_item,
  output logic out_valid,
  output srw_pkg::out_item_t out_item,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [srw_pkg::CfgDataW-1:0] cfg_data
);
  import srw_pkg::*;
  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_SCAN = 7'b0000010, S_CHK1 = 7'b0000100,
    S_CHK2 = 7'b0001000, S_REL = 7'b0010000, S_NEW = 7'b0100000,
    S_END = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;
  logic [TotW-1:0] total_r;
  logic [RenW-1:0] ren_r;
  logic [PosW-1:0] base_r, base_nxt;
  logic [TimeW-1:0] now_r, now_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic tick_r, tick_nxt;
  in_item_t item_r;
  logic [WINDOW-1:0] hit, hit_r, hit_nxt;
  logic [IW-1:0] aidx, aidx_r, aidx_nxt;
  logic [40:0] dlt;
  logic ok_r, ok_nxt;
  out_item_t res_r, res_nxt;
  logic vld_r, vld_nxt;
  logic ent_rq;
  cell_ctl_t ctl;
  logic [WINDOW-1:0] ld, rq;
  logic [TimeW-1:0] tm [WINDOW];

  // Current position under test and its length.
  logic [PosW+1:0] pos;
  logic [40:0] bstart;
  logic [LenW+2:0] plen;
  logic [IW-1:0] hidx;
  logic cur_ld, cur_rq;
  logic [TimeW-1:0] cur_tm;

  always_comb begin
    unique case (st_r)
      S_NEW: pos = {2'b0, base_r} + (PosW+2)'(WINDOW);
      S_SCAN: pos = {2'b0, base_r} + (PosW+2)'(cnt_r);
      S_CHK2: pos = {2'b0, base_r} + (PosW+2)'(aidx_r);
      default: pos = {2'b0, base_r};
    endcase
  end
  assign bstart = 41'(pos) * 41'(SEGMENT_BYTES);
  always_comb begin
    if (bstart >= 41'(total_r)) plen = '0;
    else if (41'(total_r) - bstart < 41'(SEGMENT_BYTES)) plen = (LenW+3)'(41'(total_r) - bstart);
    else plen = (LenW+3)'(SEGMENT_BYTES);
  end
  assign hidx = (st_r == S_SCAN) ? cnt_r[IW-1:0] : '0;
  assign cur_ld = ld[hidx];
  assign cur_rq = rq[hidx];
  assign cur_tm = tm[hidx];
  assign ent_rq = (st_r == S_NEW) && plen != '0;

  // Byte distance of the arrival from the window base; a slot matches only on an exact multiple.
  assign dlt = 41'(item_r.arrival_offset) - bstart;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    // The top cell takes in the segment that enters the window on a slide.
    srw_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .is_head(hidx == IW'(g)),
      .sel_ld(hit_r[g]), .now(now_r),
      .prev_ld((g == WINDOW - 1) ? 1'b0 : ld[(g+1)%WINDOW]),
      .prev_rq((g == WINDOW - 1) ? ent_rq : rq[(g+1)%WINDOW]),
      .prev_tm((g == WINDOW - 1) ? now_r : tm[(g+1)%WINDOW]),
      .ld(ld[g]), .rq(rq[g]), .tm(tm[g])
    );
    assign hit[g] = dlt == 41'(g * SEGMENT_BYTES);
  end

  always_comb begin
    aidx = '0;
    for (int k = 0; k < WINDOW; k++) begin
      if (hit[k]) aidx = IW'(k);
    end
  end

  always_comb begin
    logic [31:0] age;
    st_nxt = st_r;
    base_nxt = base_r;
    now_nxt = now_r;
    cnt_nxt = cnt_r;
    tick_nxt = tick_r;
    hit_nxt = hit_r;
    aidx_nxt = aidx_r;
    ok_nxt = ok_r;
    vld_nxt = 1'b0;
    res_nxt = res_r;
    ctl = '0;
    age = now_r - cur_tm;
    res_nxt.segment_index = pos[PosW-1:0];
    res_nxt.byte_offset = bstart[OffW-1:0];
    res_nxt.byte_length = plen[LenW-1:0];
    res_nxt.last = 1'b0;
    res_nxt.kind = KindRequest;
    unique case (st_r)
      S_IDLE: if (start && !busy) begin
        cnt_nxt = '0;
        case (in_item.mode)
          ModeStart: begin st_nxt = S_SCAN; tick_nxt = 1'b0; end
          ModeTick: begin
            st_nxt = S_SCAN; tick_nxt = 1'b1; now_nxt = now_r + 1'b1;
          end
          ModeArrival: st_nxt = S_CHK1;
          default: st_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (cnt_r == CW'(WINDOW)) st_nxt = S_END;
        else begin
          cnt_nxt = cnt_r + 1'b1;
          if (plen != '0 && !cur_ld &&
              (!tick_r || (cur_rq && age >= 32'(ren_r)))) begin
            ctl.req_head = 1'b1;
            vld_nxt = 1'b1;
          end
        end
      end
      S_CHK1: begin
        hit_nxt = hit;
        aidx_nxt = aidx;
        ok_nxt = (|hit) && item_r.arrival_length != '0;
        st_nxt = S_CHK2;
      end
      S_CHK2: begin
        if (ok_r && 16'(plen) == item_r.arrival_length) begin
          ctl.set_ld = 1'b1;
          st_nxt = S_REL;
        end else st_nxt = S_IDLE;
      end
      S_REL: begin
        if (base_r != 16'hFFFF && plen != '0 && cur_ld && cnt_r < CW'(WINDOW)) begin
          res_nxt.kind = KindDeliver;
          vld_nxt = 1'b1;
          ctl.clr_head = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          st_nxt = S_NEW;
        end else st_nxt = S_END;
      end
      S_NEW: begin
        // Slide: rotate the ring and request the segment that moves in at the top.
        ctl.rotate = 1'b1;
        base_nxt = base_r + 1'b1;
        vld_nxt = ent_rq;
        st_nxt = S_REL;
      end
      S_END: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      base_r <= '0;
      now_r <= '0;
      cnt_r <= '0;
      tick_r <= 1'b0;
      ok_r <= 1'b0;
      vld_r <= 1'b0;
      total_r <= '0;
      ren_r <= 16'd214;
    end else begin
      st_r <= st_nxt;
      base_r <= base_nxt;
      now_r <= now_nxt;
      cnt_r <= cnt_nxt;
      tick_r <= tick_nxt;
      ok_r <= ok_nxt;
      vld_r <= vld_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgTotal: total_r <= cfg_data[TotW-1:0];
          CfgRenewal: ren_r <= cfg_data[RenW-1:0];
          default: ;
        endcase
      end
    end
    hit_r <= hit_nxt;
    aidx_r <= aidx_nxt;
    res_r <= res_nxt;
    if (start && !busy) item_r <= in_item;
  end

  // Output holding register: one result per cycle; last marks the final one.
  out_item_t hold_r;
  logic hold_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) hold_v_r <= 1'b0;
    else if (vld_r) hold_v_r <= 1'b1;
    else if (st_r == S_IDLE) hold_v_r <= 1'b0;
    if (vld_r) hold_r <= res_r;
  end

  assign busy = st_r != S_IDLE || hold_v_r;
  assign out_valid = hold_v_r && (vld_r || st_r == S_IDLE);
  always_comb begin
    out_item = hold_r;
    out_item.last = st_r == S_IDLE && !vld_r;
  end

  `SRW_ASSERT(a_out_busy, clk, rst_n, out_valid |-> busy, "result outside busy")
  `SRW_ASSERT(a_base_step, clk, rst_n,
              (base_r != $past(base_r)) |-> $past(st_r == S_NEW), "base jump")
  `SRW_ASSERT(a_rel_ok, clk, rst_n, (st_r == S_REL) |-> $past(st_r == S_CHK2 ||
              st_r == S_NEW), "release out of order")
endmodule
